>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// Checks that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

>>> rtl/cbip_pkg.sv
package cbip_pkg;

  localparam int MAX_BASE  = 16;
  localparam int ALPHA_MAX = 16;
  localparam int DIGIT_W   = $clog2(ALPHA_MAX);
  localparam int LEN_W     = $clog2(ALPHA_MAX + 1);
  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN   = 2'd2;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    PH_BLANK = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] parsed_value;
    logic                      alphabet_invalid;
  } out_item_t;

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] digit;
    logic [LEN_W-1:0]   used_len;
    logic               bad;
  } alpha_info_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_CR) || (c == CH_SPACE);
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

>>> rtl/cbip_alpha.sv
module cbip_alpha (
  input  logic [cbip_pkg::CFG_DATA_W-1:0] alphabet_low,
  input  logic [cbip_pkg::CFG_DATA_W-1:0] alphabet_high,
  input  logic [cbip_pkg::LEN_W-1:0]      base_len,
  input  logic [cbip_pkg::CHAR_W-1:0]     char_code,
  output cbip_pkg::alpha_info_t           info
);
  import cbip_pkg::*;

  logic [2*CFG_DATA_W-1:0] alpha_flat;
  logic [CHAR_W-1:0]       chars [ALPHA_MAX];
  logic [ALPHA_MAX-1:0]    in_use;
  logic [ALPHA_MAX-1:0]    match;
  logic [ALPHA_MAX-1:0]    char_bad;
  logic [LEN_W-1:0]        used_len;
  logic [DIGIT_W-1:0]      first_hit;

  assign alpha_flat = {alphabet_high, alphabet_low};
  assign used_len   = (base_len > LEN_W'(MAX_BASE)) ? '0 : base_len;

  always_comb begin
    for (int k = 0; k < ALPHA_MAX; k++) begin
      chars[k]  = alpha_flat[k*CHAR_W +: CHAR_W];
      in_use[k] = LEN_W'(k) < used_len;
      match[k]  = in_use[k] && (chars[k] == char_code);
    end
  end

  // The lowest matching index wins, so scan downward and let lower hits overwrite.
  always_comb begin
    first_hit = '0;
    for (int k = ALPHA_MAX - 1; k >= 0; k--) begin
      if (match[k]) begin
        first_hit = DIGIT_W'(k);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < ALPHA_MAX; a++) begin
      char_bad[a] = in_use[a] && ((chars[a] == CH_NUL) || is_sign(chars[a]) ||
                                  is_blank(chars[a]));
      for (int b = a + 1; b < ALPHA_MAX; b++) begin
        if (in_use[a] && in_use[b] && (chars[a] == chars[b])) begin
          char_bad[a] = 1'b1;
        end
      end
    end
  end

  assign info = '{hit:      |match,
                  digit:    first_hit,
                  used_len: used_len,
                  bad:      (used_len < LEN_W'(2)) || (|char_bad)};

endmodule

>>> rtl/custom_base_integer_parser_core.sv
// Signed integer parser over a configurable digit alphabet of up to 16 characters. One
// character enters per item and a new item is taken every clock cycle, save while a last
// character waits in the input register for the result register to drain. The result
// passes the input register and a result register. The per-character step (alphabet
// lookup, one 32-by-5 multiply-add and the sign bookkeeping) is combinational logic,
// which sets the one-item-per-cycle rate. Leading blanks are skipped, any run of plus and
// minus signs sets the sign by the parity of the minus signs, and digits accumulate
// modulo 2^32 until the first character outside the alphabet. An invalid alphabet (fewer
// than two characters, a repeat, a sign, a blank or a zero byte) gives the value 0 with
// alphabet_invalid set. Write the alphabet registers only while no string is in flight.
`include "assert_macros.svh"

module custom_base_integer_parser_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cbip_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cbip_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbip_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbip_pkg::*;

  logic [CFG_DATA_W-1:0] alphabet_low;
  logic [CFG_DATA_W-1:0] alphabet_high;
  logic [LEN_W-1:0]      base_len;

  logic         s1_valid;
  in_item_t     s1_item;
  logic         advance;
  logic         finish;

  phase_t       phase;
  phase_t       phase_next;
  logic         parity;
  logic         parity_next;
  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] acc_next;
  logic [VALUE_W-1:0] acc_work;
  logic [VALUE_W-1:0] value_work;
  logic         parity_work;
  phase_t       phase_work;

  alpha_info_t  info;
  out_item_t    out_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= '0;
      alphabet_high <= '0;
      base_len      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHA_LOW:  alphabet_low  <= cfg_data;
        CFG_ALPHA_HIGH: alphabet_high <= cfg_data;
        CFG_BASE_LEN:   base_len      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A character that ends no string never needs the result register.
  assign advance  = s1_valid && (!s1_item.end_of_string || !out_valid || out_ready);
  assign finish   = advance && s1_item.end_of_string;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  cbip_alpha u_alpha (
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .base_len      (base_len),
    .char_code     (s1_item.char_code),
    .info          (info)
  );

  always_comb begin
    phase_work  = phase;
    parity_work = parity;
    acc_work    = acc;
    if (phase == PH_BLANK && !is_blank(s1_item.char_code)) begin
      phase_work = PH_SIGN;
    end
    if (phase_work == PH_SIGN) begin
      if (is_sign(s1_item.char_code)) begin
        parity_work = parity ^ (s1_item.char_code == CH_MINUS);
      end else begin
        phase_work = PH_DIGIT;
      end
    end
    // Reaching the digit phase here means the parse had not stopped before this item.
    if (phase_work == PH_DIGIT) begin
      if (info.hit) begin
        acc_work = VALUE_W'(acc * VALUE_W'(info.used_len)) + VALUE_W'(info.digit);
      end else begin
        phase_work = PH_STOP;
      end
    end
    value_work = parity_work ? (VALUE_W'(0) - acc_work) : acc_work;

    out_next.parsed_value     = info.bad ? '0 : value_work;
    out_next.alphabet_invalid = info.bad;

    phase_next  = phase;
    parity_next = parity;
    acc_next    = acc;
    if (finish) begin
      phase_next  = PH_BLANK;
      parity_next = 1'b0;
      acc_next    = '0;
    end else if (advance) begin
      phase_next  = phase_work;
      parity_next = parity_work;
      acc_next    = acc_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_BLANK;
      parity <= 1'b0;
      acc    <= '0;
    end else begin
      phase  <= phase_next;
      parity <= parity_next;
      acc    <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= out_next;
    end
  end

  `ASSERT_NEVER(a_invalid_gives_zero, clk, rst,
                out_valid && out_data.alphabet_invalid && (out_data.parsed_value != 0))
  `ASSERT_PROP(a_clear_after_last, clk, rst, finish |=> (phase == PH_BLANK) && !parity && (acc == '0))
  `ASSERT_PROP(a_stop_holds, clk, rst, (phase == PH_STOP) && !finish |=> (phase == PH_STOP))
  `ASSERT_PROP(a_stalled_item_kept, clk, rst, s1_valid && !advance |=> s1_valid && $stable(s1_item))
  `ASSERT_PROP(a_no_overwrite, clk, rst, out_valid && !out_ready |-> !finish)

endmodule
